// ===== rtl/ctc_greedy_decoder_core_macros.svh =====
// Assertion macros shared by the checker of the CTC greedy decoder.
`ifndef CTC_GREEDY_DECODER_CORE_MACROS_SVH
`define CTC_GREEDY_DECODER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CTCGD_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("ctc greedy decoder check failed");

// Implication whose consequence is checked in the next cycle.
`define CTCGD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("ctc greedy decoder check failed");

`endif

// ===== rtl/ctcgd_pkg.sv =====
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Types, constants and the exponent table of the CTC greedy decoder.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

	localparam int MAX_CLASSES = 8192;
	localparam int MAX_ROWS    = 1024;
	localparam int QUEUE_DEPTH = 4;
	localparam int EXP_BITS    = 12;

	localparam logic [13:0] NUM_KEYS_RESET = 14'd8192;
	localparam logic [12:0] CLASS_LAST     = 13'(MAX_CLASSES - 1);
	localparam logic [9:0]  ROW_LAST       = 10'(MAX_ROWS - 1);
	localparam logic [11:0] ROWS_SAT       = 12'(MAX_ROWS);

	// One input word.
	typedef struct packed {
		logic signed [15:0] logit;
		logic               row_end;
		logic               line_end;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [12:0] char_class;
		logic [9:0]  row_index;
		logic [15:0] score;
		logic [10:0] column_width;
		logic        last_of_line;
	} result_t;

	// Finished row handed from the front to the back.
	typedef struct packed {
		logic [12:0] best_class;
		logic [15:0] score;
		logic        line_end;
	} row_t;

	// Q0.16 factors round(65536*exp(-2^b/256)).
	function automatic logic [15:0] exp_k(input logic [3:0] b);
		logic [15:0] k;
		unique case (b)
			4'd0:    k = 16'd65280;
			4'd1:    k = 16'd65026;
			4'd2:    k = 16'd64520;
			4'd3:    k = 16'd63520;
			4'd4:    k = 16'd61565;
			4'd5:    k = 16'd57835;
			4'd6:    k = 16'd51039;
			4'd7:    k = 16'd39750;
			4'd8:    k = 16'd24109;
			4'd9:    k = 16'd8869;
			4'd10:   k = 16'd1200;
			4'd11:   k = 16'd22;
			default: k = 16'd0;
		endcase
		return k;
	endfunction

	// Clamp a width sum to the row limit.
	function automatic logic [10:0] sat_rows(input logic [11:0] v);
		return (v > ROWS_SAT) ? 11'(ROWS_SAT) : v[10:0];
	endfunction

endpackage

// ===== rtl/ctc_greedy_decoder_core.sv =====
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_core
// CTC greedy decoder with a fixed-point softmax score per character.
// ----------------------------------------------------------------------------
// One Q8.8 logit word is taken per item, class 0 first, row_end on the last
// class of a row. A logit that is not a row's first passes the front end in
// 12 steps of the shared exponent multiplier and one add, with one more
// multiply before the add when it is a new maximum, since the sum is then
// rescaled; a row's first logit needs none of these steps. The last logit
// of a row then goes through the bit-serial division that forms the score
// and waits to hand the row to a four-deep queue. The back end drains that
// queue on its own and gives up to two result words per row through an
// output register, so a stalled result side blocks the input only once the
// queue is full. The user writes num_keys through the cfg channel only while
// the block is idle; the block does not enforce this. That channel is always ready.
module ctc_greedy_decoder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  ctcgd_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output ctcgd_pkg::result_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [13:0]        cfg_data
);

	logic            push_valid;
	logic            push_ready;
	ctcgd_pkg::row_t push_row;
	logic            pop_valid;
	logic            pop_ready;
	ctcgd_pkg::row_t pop_row;
	logic [13:0]     num_keys_q;

	assign cfg_ready = 1'b1;

	// Key table size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_keys_q <= ctcgd_pkg::NUM_KEYS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			num_keys_q <= cfg_data;
		end
	end

	ctcgd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_row   (push_row)
	);

	ctcgd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_row   (push_row),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_row    (pop_row)
	);

	ctcgd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.num_keys     (num_keys_q),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_row      (pop_row),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== rtl/ctcgd_front.sv =====
// ----------------------------------------------------------------------------
// ctcgd_front
// Softmax front end: running max, exp sum, argmax and the row-end score.
// ----------------------------------------------------------------------------
module ctcgd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  ctcgd_pkg::item_t item,
	output logic            push_valid,
	input  logic            push_ready,
	output ctcgd_pkg::row_t push_row
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXP, ST_MUL, ST_ADD, ST_DIV, ST_PUSH
	} state_t;

	state_t             state_q;
	logic signed [15:0] max_q;
	logic [31:0]        sum_q;
	logic [12:0]        best_q;
	logic [12:0]        cc_q;
	logic [11:0]        d_q;
	logic [16:0]        acc_q;
	logic [3:0]         bit_q;
	logic               gt_q;
	logic               row_end_q;
	logic               line_end_q;
	logic [48:0]        prod_q;
	logic [32:0]        rem_q;
	logic [16:0]        quo_q;
	logic [4:0]         dcnt_q;

	logic               accept;
	logic               gt;
	logic [16:0]        d_full;
	logic [33:0]        exp_prod;
	logic [32:0]        scaled;
	logic [33:0]        add_gt;
	logic [32:0]        add_le;
	logic               div_ge;
	logic [32:0]        div_t;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	// Distance between the new logit and the running maximum.
	assign gt     = item.logit > max_q;
	assign d_full = gt ? (17'({item.logit[15], item.logit}) - 17'({max_q[15], max_q}))
	                   : (17'({max_q[15], max_q}) - 17'({item.logit[15], item.logit}));

	// One table factor per set distance bit, rounded back to Q0.16.
	assign exp_prod = 34'(acc_q * ctcgd_pkg::exp_k(bit_q)) + 34'd32768;

	// Sum update for a new maximum and for a logit not above the maximum.
	assign scaled = 33'((prod_q + 49'd32768) >> 16);
	assign add_gt = 34'(scaled) + 34'd65536;
	assign add_le = 33'(sum_q) + 33'(acc_q);

	// One quotient bit of 2^32 / sum per cycle.
	assign div_ge = rem_q >= {1'b0, sum_q};
	assign div_t  = div_ge ? (rem_q - {1'b0, sum_q}) : rem_q;

	assign push_valid          = (state_q == ST_PUSH);
	assign push_row.best_class = best_q;
	assign push_row.score      = quo_q[16] ? 16'hFFFF : quo_q[15:0];
	assign push_row.line_end   = line_end_q;

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_q   <= '0;
			sum_q   <= '0;
			best_q  <= '0;
			cc_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						row_end_q  <= item.row_end;
						line_end_q <= item.line_end;
						gt_q       <= gt;
						d_q        <= d_full[11:0];
						acc_q      <= (d_full[16:12] != '0) ? 17'd0 : 17'd65536;
						bit_q      <= '0;
						if (item.row_end) begin
							cc_q <= '0;
						end else if (cc_q < ctcgd_pkg::CLASS_LAST) begin
							cc_q <= cc_q + 13'd1;
						end
						if (cc_q == '0) begin
							max_q  <= item.logit;
							sum_q  <= 32'd65536;
							best_q <= '0;
							state_q <= item.row_end ? ST_DIV : ST_IDLE;
						end else begin
							if (gt) begin
								max_q  <= item.logit;
								best_q <= cc_q;
							end
							state_q <= ST_EXP;
						end
						rem_q  <= 33'd65536;
						quo_q  <= '0;
						dcnt_q <= '0;
					end
				end
				ST_EXP: begin
					if (d_q[bit_q]) begin
						acc_q <= exp_prod[32:16];
					end
					bit_q <= bit_q + 4'd1;
					if (bit_q == 4'(ctcgd_pkg::EXP_BITS - 1)) begin
						state_q <= gt_q ? ST_MUL : ST_ADD;
					end
				end
				ST_MUL: begin
					prod_q  <= sum_q * acc_q;
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (gt_q) begin
						sum_q <= (add_gt[33:32] != '0) ? 32'hFFFF_FFFF : add_gt[31:0];
					end else begin
						sum_q <= add_le[32] ? 32'hFFFF_FFFF : add_le[31:0];
					end
					state_q <= row_end_q ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					quo_q  <= {quo_q[15:0], div_ge};
					rem_q  <= {div_t[31:0], 1'b0};
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd16) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/ctcgd_queue.sv =====
// ----------------------------------------------------------------------------
// ctcgd_queue
// Small queue of finished rows between the front and the back.
// ----------------------------------------------------------------------------
module ctcgd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  ctcgd_pkg::row_t push_row,
	output logic            pop_valid,
	input  logic            pop_ready,
	output ctcgd_pkg::row_t pop_row
);

	localparam int PW = $clog2(ctcgd_pkg::QUEUE_DEPTH);

	ctcgd_pkg::row_t entry_q [ctcgd_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [PW:0]     count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != (PW+1)'(ctcgd_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_row    = entry_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_row;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ctcgd_back.sv =====
// ----------------------------------------------------------------------------
// ctcgd_back
// CTC collapse: gap counting, held character and result words.
// ----------------------------------------------------------------------------
module ctcgd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [13:0]        num_keys,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  ctcgd_pkg::row_t    pop_row,
	output logic               result_valid,
	input  logic               result_stall,
	output ctcgd_pkg::result_t result
);

	logic [12:0]        prev_q;
	logic [10:0]        gap_q;
	logic [9:0]         row_q;
	logic               pv_q;
	logic [12:0]        pc_q;
	logic [9:0]         pr_q;
	logic [15:0]        ps_q;
	logic [10:0]        pw_q;
	logic               res_valid_q;
	ctcgd_pkg::result_t res_q;
	logic               sec_valid_q;
	ctcgd_pkg::result_t sec_q;

	logic               out_free;
	logic               pop;
	logic [12:0]        m;
	logic [12:0]        prev_n;
	logic [10:0]        gap_n;
	logic [9:0]         row_n;
	logic               pv_n;
	logic [12:0]        pc_n;
	logic [9:0]         pr_n;
	logic [15:0]        ps_n;
	logic [10:0]        pw_n;
	logic               r1_v;
	logic               r2_v;
	ctcgd_pkg::result_t r1;
	ctcgd_pkg::result_t r2;

	assign out_free     = !res_valid_q || !result_stall;
	assign pop          = pop_valid && !sec_valid_q && out_free;
	assign pop_ready    = !sec_valid_q && out_free;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign m            = pop_row.best_class;

	// Next state of the collapse for one finished row.
	always_comb begin
		prev_n = prev_q;
		gap_n  = gap_q;
		row_n  = row_q;
		pv_n   = pv_q;
		pc_n   = pc_q;
		pr_n   = pr_q;
		ps_n   = ps_q;
		pw_n   = pw_q;
		r1_v   = 1'b0;
		r2_v   = 1'b0;
		r1     = '0;
		r2     = '0;
		if (m == '0 || m == prev_q) begin
			gap_n = ctcgd_pkg::sat_rows(12'(gap_q) + 12'd1);
		end else if (14'(m) < num_keys) begin
			if (pv_q) begin
				r1_v = 1'b1;
				r1.char_class   = pc_q;
				r1.row_index    = pr_q;
				r1.score        = ps_q;
				r1.column_width = ctcgd_pkg::sat_rows(12'(pw_q) + 12'(gap_q[10:1]));
				r1.last_of_line = 1'b0;
				pw_n = ctcgd_pkg::sat_rows(12'(gap_q[10:1]) + 12'd1);
			end else begin
				pw_n = ctcgd_pkg::sat_rows(12'(gap_q) + 12'd1);
			end
			pv_n  = 1'b1;
			pc_n  = m;
			pr_n  = row_q;
			ps_n  = pop_row.score;
			gap_n = '0;
		end
		prev_n = m;
		if (pop_row.line_end) begin
			if (pv_n) begin
				r2_v = 1'b1;
				r2.char_class   = pc_n;
				r2.row_index    = pr_n;
				r2.score        = ps_n;
				r2.column_width = ctcgd_pkg::sat_rows(12'(pw_n) + 12'(gap_n));
				r2.last_of_line = 1'b1;
			end
			pv_n   = 1'b0;
			prev_n = '0;
			gap_n  = '0;
			row_n  = '0;
		end else if (row_q < ctcgd_pkg::ROW_LAST) begin
			row_n = row_q + 10'd1;
		end
	end

	// Payload registers of the held character and result words.
	always_ff @(posedge clk) begin
		if (pop) begin
			pc_q <= pc_n;
			pr_q <= pr_n;
			ps_q <= ps_n;
			pw_q <= pw_n;
		end
		if (out_free) begin
			if (sec_valid_q) begin
				res_q <= sec_q;
			end else if (pop) begin
				res_q <= r1_v ? r1 : r2;
				sec_q <= r2;
			end
		end
	end

	// Control state of the collapse and the output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			gap_q       <= '0;
			row_q       <= '0;
			pv_q        <= 1'b0;
			res_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				prev_q <= prev_n;
				gap_q  <= gap_n;
				row_q  <= row_n;
				pv_q   <= pv_n;
			end
			if (out_free) begin
				if (sec_valid_q) begin
					res_valid_q <= 1'b1;
					sec_valid_q <= 1'b0;
				end else if (pop) begin
					res_valid_q <= r1_v || r2_v;
					sec_valid_q <= r1_v && r2_v;
				end else begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== rtl/ctcgd_checker.sv =====
// ----------------------------------------------------------------------------
// ctcgd_checker
// Port-level checks of the CTC greedy decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "ctc_greedy_decoder_core_macros.svh"

module ctcgd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_stall,
	input ctcgd_pkg::result_t result
);

	// A stalled result word holds.
	`CTCGD_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid && $stable(result))

	// The score is never zero since the sum stays below 2^32.
	`CTCGD_ASSERT_IMPLY(a_score_nz, result_valid, result.score != 16'd0)

	// A character is never blank and always covers at least one row.
	`CTCGD_ASSERT_IMPLY(a_char_ok, result_valid, result.char_class != 13'd0 && result.column_width != 11'd0)

	// Widths stay within the row limit.
	`CTCGD_ASSERT_IMPLY(a_width_max, result_valid, result.column_width <= 11'd1024)

endmodule

bind ctc_greedy_decoder_core ctcgd_checker u_ctcgd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ===== bench/ctc_greedy_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// ctc_greedy_decoder_core_test
// Self-checking bench for the CTC greedy decoder core. Rows of logit words
// are streamed in with random gaps on the input and random stalls on the
// output. A scoreboard predicts each decoded character and compares it,
// field by field, with what the core returns. The run steps through several
// num_keys settings.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 900000;
	localparam int          SETTLE      = 150;

	// Decoder prediction and the queue of characters still owed by the core.
	class char_scoreboard;
		int unsigned          keys_limit;
		int                   row_max;
		int unsigned          exp_total;
		int unsigned          win_class;
		int unsigned          class_idx;
		int unsigned          row_idx;
		int unsigned          last_class;
		int unsigned          gap_rows;
		bit                   held_valid;
		int unsigned          held_class;
		int unsigned          held_row;
		int unsigned          held_score;
		int unsigned          held_width;
		ctcgd_pkg::result_t   owed_q[$];
		int                   mismatches;
		int                   chars_seen;

		function new();
			keys_limit = ctcgd_pkg::NUM_KEYS_RESET;
			row_max    = 0;
			exp_total  = 0;
			win_class  = 0;
			class_idx  = 0;
			row_idx    = 0;
			last_class = 0;
			gap_rows   = 0;
			held_valid = 0;
			held_class = 0;
			held_row   = 0;
			held_score = 0;
			held_width = 0;
			mismatches = 0;
			chars_seen = 0;
		endfunction

		// Q0.16 approximation of exp(-d/256) built from the per-bit factors.
		function int unsigned decay(int unsigned d);
			longint unsigned acc;
			int unsigned factor[12] = '{65280, 65026, 64520, 63520, 61565, 57835,
				51039, 39750, 24109, 8869, 1200, 22};
			acc = 65536;
			if (d >= 4096)
				return 0;
			for (int b = 0; b < 12; b++)
				if (d[b])
					acc = (acc * factor[b] + 32768) >> 16;
			return int'(acc);
		endfunction

		function int unsigned clip32(longint unsigned v);
			return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
		endfunction

		function int unsigned clip_rows(int unsigned v);
			return (v > ctcgd_pkg::MAX_ROWS) ? ctcgd_pkg::MAX_ROWS : v;
		endfunction

		function void owe(int unsigned cls, int unsigned row, int unsigned sc,
				int unsigned wd, bit last);
			ctcgd_pkg::result_t r;
			r.char_class   = cls[12:0];
			r.row_index    = row[9:0];
			r.score        = sc[15:0];
			r.column_width = wd[10:0];
			r.last_of_line = last;
			owed_q.push_back(r);
		endfunction

		// Track one accepted input word.
		function void note_item(ctcgd_pkg::item_t it);
			int              x;
			int unsigned     sc;
			int unsigned     half;
			longint unsigned q;
			x = $signed(it.logit);
			if (class_idx == 0) begin
				row_max   = x;
				exp_total = 65536;
				win_class = 0;
			end else if (x > row_max) begin
				q = (longint'(exp_total) * decay(x - row_max) + 32768) >> 16;
				exp_total = clip32(q + 65536);
				row_max   = x;
				win_class = class_idx;
			end else begin
				exp_total = clip32(longint'(exp_total) + decay(row_max - x));
			end
			if (!it.row_end) begin
				if (class_idx < ctcgd_pkg::MAX_CLASSES - 1)
					class_idx++;
				return;
			end
			class_idx = 0;
			q  = 64'h1_0000_0000 / exp_total;
			sc = (q > 65535) ? 65535 : q[31:0];

			// Collapse blanks and repeats into the gap.
			if (win_class == 0 || win_class == last_class) begin
				gap_rows = clip_rows(gap_rows + 1);
			end else if (win_class < keys_limit) begin
				half = gap_rows / 2;
				if (held_valid) begin
					owe(held_class, held_row, held_score, clip_rows(held_width + half), 0);
					held_width = clip_rows(half + 1);
				end else begin
					held_width = clip_rows(gap_rows + 1);
				end
				held_valid = 1;
				held_class = win_class;
				held_row   = row_idx;
				held_score = sc;
				gap_rows   = 0;
			end
			last_class = win_class;

			if (it.line_end) begin
				if (held_valid)
					owe(held_class, held_row, held_score, clip_rows(held_width + gap_rows), 1);
				held_valid = 0;
				last_class = 0;
				gap_rows   = 0;
				row_idx    = 0;
			end else if (row_idx < ctcgd_pkg::MAX_ROWS - 1) begin
				row_idx++;
			end
		endfunction

		// Compare one returned character with the oldest one owed.
		function void check_char(ctcgd_pkg::result_t got);
			ctcgd_pkg::result_t want;
			chars_seen++;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected character: got %p", got);
				return;
			end
			want = owed_q.pop_front();
			if (got.char_class !== want.char_class || got.row_index !== want.row_index
					|| got.score !== want.score || got.column_width !== want.column_width
					|| got.last_of_line !== want.last_of_line) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Character mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	ctcgd_pkg::item_t   item;
	logic               result_valid;
	logic               result_stall;
	ctcgd_pkg::result_t result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [13:0]        cfg_data;

	char_scoreboard chars = new();
	bit             calm;
	int unsigned    cycles;
	int unsigned    words_sent;
	int unsigned    stall_left;
	int unsigned    flow_left;
	int             prev_win;

	ctc_greedy_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: random stall bursts, checking of every accepted word.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			chars.check_char(result);
		if (calm) begin
			result_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left   <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (flow_left != 0) begin
			flow_left    <= flow_left - 1;
			result_stall <= 1'b0;
		end else if ($urandom_range(0, 2) == 0) begin
			stall_left   <= $urandom_range(0, 12);
			result_stall <= 1'b1;
		end else begin
			flow_left    <= $urandom_range(1, 40);
			result_stall <= 1'b0;
		end
	end

	// Send one word, with an occasional idle burst before it.
	task automatic send_word(logic [15:0] lg, bit re, bit le);
		ctcgd_pkg::item_t it;
		it.logit    = lg;
		it.row_end  = re;
		it.line_end = le;
		if (!calm && $urandom_range(0, 11) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		chars.note_item(it);
		words_sent++;
	endtask

	// Send one row of n classes; class win gets the peak, a negative win
	// makes all logits equal, wild rows use fully random logits.
	task automatic send_row(int n, int win, bit le, bit wild);
		logic [15:0] lg;
		logic [15:0] flat;
		flat = $urandom;
		for (int c = 0; c < n; c++) begin
			if (wild)
				lg = $urandom;
			else if (win < 0)
				lg = flat;
			else if (c == win)
				lg = 16'($urandom_range(400, 2000));
			else
				lg = 16'($signed($urandom_range(0, 700)) - 350);
			if (c == n - 1)
				send_word(lg, 1'b1, le);
			else
				send_word(lg, 1'b0, $urandom_range(0, 15) == 0);
		end
	endtask

	// Random line with blanks, repeats and new classes below max_cls.
	task automatic send_line(int max_cls);
		int rows;
		int win;
		int n;
		rows = $urandom_range(1, 20);
		prev_win = 0;
		for (int r = 0; r < rows; r++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: win = 0;
				3, 4:    win = prev_win;
				default: win = $urandom_range(1, max_cls - 1);
			endcase
			n = $urandom_range(win + 1, max_cls);
			if ($urandom_range(0, 30) == 0)
				n = $urandom_range(win + 1, 60);
			if ($urandom_range(0, 15) == 0)
				send_row(n, -1, r == rows - 1, 1'b0);
			else
				send_row(n, win, r == rows - 1, $urandom_range(0, 9) == 0);
			prev_win = win;
		end
	endtask

	// Let everything owed come back, then let the pipeline settle.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (chars.owed_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write num_keys; the core is idle here.
	task automatic write_keys(int unsigned keys);
		cfg_valid <= 1'b1;
		cfg_data  <= 14'(keys);
		do @(posedge clk); while (!cfg_ready);
		chars.keys_limit = keys;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int words, int max_cls);
		int unsigned stop_at;
		stop_at = words_sent + words;
		while (words_sent < stop_at)
			send_line(max_cls);
	endtask

	initial begin
		int unsigned settings[5];
		settings     = '{1, 3, 8192, 7, 2};
		calm         = 1'b0;
		cycles       = 0;
		words_sent   = 0;
		stall_left   = 0;
		flow_left    = 0;
		prev_win     = 0;
		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		item         <= '0;
		result_stall <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_data     <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, ties, stray line ends, empty line, two results.
		send_word(16'h8000, 1'b0, 1'b1);
		send_word(16'h7FFF, 1'b1, 1'b0);
		send_word(16'h8000, 1'b0, 1'b0);
		send_word(16'h8000, 1'b1, 1'b1);
		send_word(16'h0000, 1'b1, 1'b1);
		send_row(3, -1, 1'b0, 1'b0);
		send_row(4, 2, 1'b0, 1'b0);
		send_row(4, 2, 1'b0, 1'b0);
		send_row(4, 0, 1'b0, 1'b0);
		send_row(4, 3, 1'b1, 1'b0);
		drain();

		// Long line: row index, gap and width saturate.
		for (int r = 0; r < ctcgd_pkg::MAX_ROWS + 10; r++)
			send_row((r == 0 || r == ctcgd_pkg::MAX_ROWS + 4) ? 2 : 1,
				(r == 0 || r == ctcgd_pkg::MAX_ROWS + 4) ? 1 : 0,
				r == ctcgd_pkg::MAX_ROWS + 9, 1'b0);
		drain();

		// Random lines under several key table sizes.
		random_phase(100, 10);
		drain();
		foreach (settings[i]) begin
			write_keys(settings[i]);
			random_phase(40, 12);
			drain();
		end

		// Final part without any idling.
		calm = 1'b1;
		write_keys($urandom_range(2, 9));
		random_phase(100, 10);
		drain();

		$display("Sent %0d words; checked %0d characters across %0d key settings.",
			words_sent, chars.chars_seen, 7);
		$display("Covered long lines, ties, stray line ends and gaps.");
		if (chars.mismatches == 0 && chars.owed_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d characters missing.",
				chars.mismatches, chars.owed_q.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
